@@ design/usan_pkg.sv @@
// usan_pkg: shared types, constants and byte-class functions for the
// utf-8 value sanitiser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package usan_pkg;

    // field widths and limits
    localparam int BYTE_W          = 8;
    localparam int LIMIT_W         = 10;
    localparam int COUNT_BITS_DEF  = 10;
    localparam int MAX_RES         = 4;
    localparam int RES_CNT_W       = 3;
    localparam int HELD_DEPTH      = 3;

    // result queue sizing
    localparam int QDEPTH          = 8;
    localparam int QPTR_W          = 3;
    localparam int QCNT_W          = 4;

    // configuration port
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;
    localparam logic [ADDR_W-1:0] ADDR_OUTPUT_LIMIT = 3'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 10'd512;

    // byte constants
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_LBRACKET   = 8'h5b;
    localparam logic [7:0] CH_RBRACKET   = 8'h5d;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DEL        = 8'h7f;
    localparam logic [7:0] LEAD_C2       = 8'hc2;
    localparam logic [7:0] LEAD_DF       = 8'hdf;
    localparam logic [7:0] LEAD_E0       = 8'he0;
    localparam logic [7:0] LEAD_ED       = 8'hed;
    localparam logic [7:0] LEAD_EF       = 8'hef;
    localparam logic [7:0] LEAD_F0       = 8'hf0;
    localparam logic [7:0] LEAD_F4       = 8'hf4;
    localparam logic [7:0] CONT_LO       = 8'h80;
    localparam logic [7:0] CONT_HI       = 8'hbf;
    localparam logic [7:0] CONT_A0       = 8'ha0;
    localparam logic [7:0] CONT_90       = 8'h90;
    localparam logic [7:0] CONT_9F       = 8'h9f;
    localparam logic [7:0] CONT_8F       = 8'h8f;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } usan_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
    } usan_out_t;

    // results of one input beat, handed to the queue in one go
    typedef struct packed {
        logic [RES_CNT_W-1:0]  count;
        usan_out_t [MAX_RES-1:0] beat;
    } usan_push_t;

    // queue status seen by the top level
    typedef struct packed {
        logic [QCNT_W-1:0] fill;
        logic              room;
    } usan_qstat_t;

    // sequence length implied by a lead byte, zero when not a lead
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd0;
        if (c >= LEAD_C2 && c <= LEAD_DF)
            len = 3'd2;
        else if (c >= LEAD_E0 && c <= LEAD_EF)
            len = 3'd3;
        else if (c >= LEAD_F0 && c <= LEAD_F4)
            len = 3'd4;
        return len;
    endfunction

    // strict second-byte range for a given lead
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (lead == LEAD_E0)
            lo = CONT_A0;
        else if (lead == LEAD_ED)
            hi = CONT_9F;
        else if (lead == LEAD_F0)
            lo = CONT_90;
        else if (lead == LEAD_F4)
            hi = CONT_8F;
        return (b >= lo) && (b <= hi);
    endfunction

    // controls, space, del and brackets map to underscore
    function automatic logic [7:0] clean_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c <= CH_SPACE || c == CH_DEL || c == CH_LBRACKET || c == CH_RBRACKET)
            r = CH_UNDERSCORE;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/usan_scan.sv @@
// usan_scan: per-byte utf-8 decode, sanitise and output cap, with the
// string state registers; depends on usan_pkg
`timescale 1ns / 1ps
`default_nettype none

module usan_scan
    import usan_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire usan_in_t           beat,
    input  wire logic [LIMIT_W-1:0] limit,
    output usan_push_t              push
);

    localparam int CAPW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam int SUMW = CAPW + 1;

    logic [7:0]            held_reg [HELD_DEPTH];
    logic [7:0]            held_next [HELD_DEPTH];
    logic [1:0]            hcnt_reg, hcnt_next;
    logic [2:0]            slen_reg, slen_next;
    logic [COUNT_BITS-1:0] emit_reg, emit_next;
    logic                  stop_reg, stop_next;

    logic [CAPW-1:0]       cap;
    logic [CAPW-1:0]       cnt_max;
    logic [CAPW-1:0]       limit_ext;
    logic [SUMW-1:0]       cnt_ext;
    logic [SUMW-1:0]       avail;

    // effective cap is the smaller of the register and the counter range
    always_comb
    begin
        cnt_max   = CAPW'({COUNT_BITS{1'b1}});
        limit_ext = CAPW'(limit);
        cap       = (limit_ext < cnt_max) ? limit_ext : cnt_max;
        cnt_ext   = SUMW'(emit_reg);
        avail     = (SUMW'(cap) > cnt_ext) ? (SUMW'(cap) - cnt_ext) : '0;
    end

    // decode one byte against the held lead
    always_comb
    begin
        logic [7:0]           b;
        logic                 fin;
        logic [2:0]           lead_len;
        logic                 ok;
        logic                 fresh;
        logic                 bulk;
        logic [1:0]           rel;
        logic                 tpres;
        logic [7:0]           tb;
        logic [2:0]           ne;
        logic [2:0]           nres;
        logic                 marker;
        logic [RES_CNT_W-1:0] total;
        logic [7:0]           e [MAX_RES];
        logic [7:0]           s [MAX_RES];
        logic [7:0]           bytes [MAX_RES];

        b        = beat.in_byte;
        fin      = beat.string_end;
        lead_len = lead_length(b);
        ok       = (hcnt_reg == 2'd1) ? second_ok(held_reg[0], b)
                                      : (b >= CONT_LO && b <= CONT_HI);
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        slen_next = slen_reg;
        stop_next = stop_reg;
        fresh     = 1'b0;
        bulk      = 1'b0;
        rel       = 2'd0;
        tpres     = 1'b0;
        tb        = CH_UNDERSCORE;

        if (stop_reg)
        begin
            hcnt_next = 2'd0;
            slen_next = 3'd0;
        end
        else if (hcnt_reg == 2'd0)
        begin
            fresh = 1'b1;
        end
        else if (!ok)
        begin
            // broken sequence: held bytes go out raw, byte is rescanned
            rel       = hcnt_reg;
            fresh     = 1'b1;
            hcnt_next = 2'd0;
            slen_next = 3'd0;
        end
        else if ((3'(hcnt_reg) + 3'd1) >= slen_reg)
        begin
            hcnt_next = 2'd0;
            slen_next = 3'd0;
            if (slen_reg == 3'd2 && held_reg[0] == LEAD_C2 && b <= CONT_9F)
            begin
                tpres = 1'b1;
                tb    = CH_UNDERSCORE;
            end
            else
            begin
                bulk = 1'b1;
            end
        end
        else
        begin
            held_next[hcnt_reg] = b;
            hcnt_next           = hcnt_reg + 2'd1;
            if (fin)
            begin
                rel   = hcnt_reg;
                tpres = 1'b1;
                tb    = b;
            end
        end

        // fresh scan: start a sequence or pass a cleaned byte
        if (fresh)
        begin
            if (lead_len != 3'd0)
            begin
                held_next[0] = b;
                hcnt_next    = 2'd1;
                slen_next    = lead_len;
                if (fin)
                begin
                    tpres = 1'b1;
                    tb    = b;
                end
            end
            else
            begin
                tpres = 1'b1;
                tb    = clean_byte(b);
            end
        end

        // ordered list of single-byte emits
        for (int k = 0; k < HELD_DEPTH; k++)
        begin
            e[k] = (2'(k) < rel) ? held_reg[k] : tb;
        end
        e[MAX_RES-1] = tb;
        ne = 3'(rel) + 3'(tpres);

        // whole sequence in order
        s[0] = held_reg[0];
        s[1] = (slen_reg == 3'd2) ? b : held_reg[1];
        s[2] = (slen_reg == 3'd3) ? b : held_reg[2];
        s[3] = b;

        // apply the cap
        if (bulk)
        begin
            bytes = s;
            if (cnt_ext + SUMW'(slen_reg) > SUMW'(cap))
            begin
                nres      = 3'd0;
                stop_next = 1'b1;
            end
            else
            begin
                nres = slen_reg;
            end
        end
        else
        begin
            bytes = e;
            if (SUMW'(ne) > avail)
            begin
                nres      = avail[2:0];
                stop_next = 1'b1;
            end
            else
            begin
                nres = ne;
            end
        end

        emit_next = emit_reg + COUNT_BITS'(nres);

        // result beats
        marker = fin && (nres == 3'd0);
        total  = marker ? RES_CNT_W'(1) : RES_CNT_W'(nres);
        for (int k = 0; k < MAX_RES; k++)
        begin
            push.beat[k].out_byte    = marker ? 8'd0 : bytes[k];
            push.beat[k].has_byte    = !marker;
            push.beat[k].run_last    = (RES_CNT_W'(k + 1) == total);
            push.beat[k].string_done = (RES_CNT_W'(k + 1) == total) && fin;
        end
        push.count = fire ? total : '0;
    end

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg <= 2'd0;
            slen_reg <= 3'd0;
            emit_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (beat.string_end)
            begin
                hcnt_reg <= 2'd0;
                slen_reg <= 3'd0;
                emit_reg <= '0;
                stop_reg <= 1'b0;
            end
            else
            begin
                hcnt_reg <= hcnt_next;
                slen_reg <= slen_next;
                emit_reg <= emit_next;
                stop_reg <= stop_next;
            end
        end
    end

    // held lead and continuation bytes
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

@@ design/usan_queue.sv @@
// usan_queue: result queue taking up to four beats per cycle and giving
// one per cycle while dst_ready is high; depends on usan_pkg
`timescale 1ns / 1ps
`default_nettype none

module usan_queue
    import usan_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire usan_push_t push,
    output logic            dst_valid,
    input  wire logic       dst_ready,
    output usan_out_t       dst_beat,
    output usan_qstat_t     stat
);

    usan_out_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              pop;

    // head of queue drives the result port
    assign dst_valid = (fill_reg != '0);
    assign dst_beat  = mem_reg[rd_ptr_reg];
    assign pop       = dst_valid && dst_ready;

    assign stat.fill = fill_reg;
    assign stat.room = (fill_reg <= QCNT_W'(QDEPTH - MAX_RES));

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        fill_next   = fill_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // write the new beats at consecutive slots
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (RES_CNT_W'(k) < push.count)
            begin
                mem_reg[wr_ptr_reg + QPTR_W'(k)] <= push.beat[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/utf8_value_sanitizer_core.sv @@
// utf8_value_sanitizer_core: top level with input register, config
// register and checks; depends on usan_pkg, usan_scan, usan_queue
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------
//  src     | in  | src_valid/src_ready| usan_in_t  (in_byte, string_end)
//  dst     | out | dst_valid/dst_ready| usan_out_t (out_byte .. done)
//  apb     | in  | psel/penable/pready| output_limit at address 0
//
// one byte per cycle while the queue has room: a byte is held in the input
// register, is decoded and its 0..4 results land in the queue as it advances.
// the queue holds 8 beats; the input stalls while fewer than 4 are free.
// results leave one per cycle while dst_ready is high, which sets the sustained rate.
// reset clears string state and queue, output_limit returns to 512.
`timescale 1ns / 1ps
`default_nettype none

module utf8_value_sanitizer_core
    import usan_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire usan_in_t          src_beat,
    output logic                   dst_valid,
    input  wire logic              dst_ready,
    output usan_out_t              dst_beat,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic               in_vld_reg;
    usan_in_t           in_beat_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               advance;
    usan_push_t         push;
    usan_qstat_t        qstat;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OUTPUT_LIMIT) ? DATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_OUTPUT_LIMIT)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // input register, moves on when the queue has room for a full burst
    assign advance   = in_vld_reg && qstat.room;
    assign src_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            in_vld_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
        begin
            in_beat_reg <= src_beat;
        end
    end

    usan_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .beat  (in_beat_reg),
        .limit (limit_reg),
        .push  (push)
    );

    usan_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_beat  (dst_beat),
        .stat      (qstat)
    );

    // checks

    // queue never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.fill <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // a bare end marker closes both the run and the string
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_beat.has_byte) |->
            (dst_beat.run_last && dst_beat.string_done && dst_beat.out_byte == 8'd0))
        else $error("malformed end marker");

    // end of string is always the last beat of its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_beat.string_done) |-> dst_beat.run_last)
        else $error("string end not on last beat of run");

    // a string end always produces at least one beat
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_beat_reg.string_end) |-> (push.count != '0))
        else $error("string end produced no result");

endmodule

`default_nettype wire
